### sv/address_sample_histogram_ranker_defines.svh
// Assertion macros used by the histogram ranker's top level.
`ifndef ADDRESS_SAMPLE_HISTOGRAM_RANKER_DEFINES_SVH
`define ADDRESS_SAMPLE_HISTOGRAM_RANKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ASHR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASHR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ashr_pkg.sv
// Types and constants of the address sample histogram ranker.
package ashr_pkg;

    localparam int GROUP_SIZE = 64;
    localparam int PAGE_BYTES = 4096;
    localparam int GRP_SH     = 6;
    localparam int PAGE_SH    = 12;
    localparam int SUM_W      = 28;

    localparam logic [2:0] FN_SAMPLE = 3'd0;
    localparam logic [2:0] FN_LSUM   = 3'd1;
    localparam logic [2:0] FN_LDET   = 3'd2;
    localparam logic [2:0] FN_PDET   = 3'd3;
    localparam logic [2:0] FN_PRANK  = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] addr;
    } t_in_item;

    typedef struct packed {
        logic [15:0] entry_addr;
        logic [27:0] entry_count;
        logic [27:0] group_total;
        logic [6:0]  nonzero_entries;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_bk_stat;

endpackage

### sv/address_sample_histogram_ranker.sv
// Top level of the address sample histogram ranker.
// Input channel: i_in_valid / o_in_stall carry one transaction of func and addr.
// Output channel: o_out_valid / i_out_stall carry the result items of each query.
// A four-deep input queue decouples acceptance from the back end, so samples
// and queries are taken while an earlier result still waits at the output.
// After reset the counter memory is cleared in one pass over all 2^ADDR_BITS
// counters, one counter per cycle; o_in_stall stays high until it is done.
// A sample in the back end reads its counter, writes it back incremented and returns to idle.
// A line sum walks 64 counters. Line detail reads 64 counters, page detail 4096
// and page ranking 2^ADDR_BITS, one per cycle on the single counter port; then
// each emitted entry costs one scan of the n entries stored in the scratch buffer.
// The counter memory read port sets every walk; the scratch scan sets emission.
// A stalled output holds its item; the back end waits and the queue fills.
// Functions 5 to 7 are taken and dropped without a result.
module address_sample_histogram_ranker #(
    parameter int ADDR_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ashr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ashr_pkg::t_out_item o_out_item
);
`include "address_sample_histogram_ranker_defines.svh"

    ashr_pkg::t_bk_stat w_stat;
    logic               w_q_valid;
    ashr_pkg::t_in_item w_q_item;

    // Accept and queue transactions.
    ashr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_stat     (w_stat),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item)
    );

    // Execute samples and queries; hold results in the output register.
    ashr_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    `ASHR_ASSERT_IMP(a_pop_needs_item, w_stat.pop, w_q_valid, "pop from empty queue")
    `ASHR_ASSERT_IMP(a_no_out_clearing, w_stat.clearing, !o_out_valid, "result during clear")
    `ASHR_ASSERT_NXT(a_clear_blocks_pop, w_stat.clearing, !$past(w_stat.pop), "pop during clear")
endmodule

### sv/ashr_front.sv
// Input queue: accept transactions, drop unused functions, hand them to the back end.
module ashr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ashr_pkg::t_in_item  i_in_item,
    input  ashr_pkg::t_bk_stat  i_stat,
    output logic                o_q_valid,
    output ashr_pkg::t_in_item  o_q_item
);
    localparam int DEPTH = 4;

    ashr_pkg::t_in_item r_q [DEPTH];
    logic [1:0] r_wp, n_wp, r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       w_acc, w_push, w_pop;

    assign o_in_stall = (r_cnt == 3'(DEPTH)) || i_stat.clearing;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_push     = w_acc && (i_in_item.func <= ashr_pkg::FN_PRANK);
    assign w_pop      = i_stat.pop && (r_cnt != 3'd0);
    assign o_q_valid  = (r_cnt != 3'd0);
    assign o_q_item   = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp + 2'(w_push);
        n_rp  = r_rp + 2'(w_pop);
        n_cnt = r_cnt + 3'(w_push) - 3'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_in_item;
        end
    end
endmodule

### sv/ashr_back.sv
// Back end: counter memory, walks for sums, selection sort, output register.
module ashr_back #(
    parameter int ADDR_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  ashr_pkg::t_in_item  i_q_item,
    output ashr_pkg::t_bk_stat  o_stat,
    output logic                o_out_valid,
    output ashr_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    localparam int AW   = ADDR_BITS;
    localparam int MEM  = 1 << ADDR_BITS;
    localparam int NP   = MEM / ashr_pkg::PAGE_BYTES;
    localparam int SCR  = (NP > ashr_pkg::GROUP_SIZE) ? NP : ashr_pkg::GROUP_SIZE;
    localparam int SW   = $clog2(SCR);
    localparam int NW   = SW + 1;
    localparam int JW   = ashr_pkg::PAGE_SH;
    localparam int CW   = ashr_pkg::SUM_W;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SRD    = 4'd2;
    localparam logic [3:0] ST_SWR    = 4'd3;
    localparam logic [3:0] ST_WALK   = 4'd4;
    localparam logic [3:0] ST_DRAIN  = 4'd5;
    localparam logic [3:0] ST_SEL    = 4'd6;
    localparam logic [3:0] ST_SDRAIN = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    typedef struct packed {
        logic [AW-1:0] a;
        logic [CW-1:0] c;
    } t_scr;

    logic [15:0] r_cnt_mem [MEM];
    logic [15:0] r_cnt_q;
    t_scr        r_scr_mem [SCR];
    t_scr        r_scr_q;

    logic [3:0]    r_st, n_st;
    logic [AW-1:0] r_clr, n_clr;
    logic [2:0]    r_func, n_func;
    logic [AW-1:0] r_addr, n_addr;
    logic [SW-1:0] r_o, n_o;
    logic [JW-1:0] r_j, n_j;
    logic          r_pv, n_pv, r_plast, n_plast;
    logic [AW-1:0] r_pbase, n_pbase;
    logic [CW-1:0] r_acc, n_acc, r_tot, n_tot;
    logic [6:0]    r_nz, n_nz, r_k, n_k;
    logic [NW-1:0] r_n, n_n;
    logic [SW-1:0] r_si, n_si;
    logic          r_spv, n_spv, r_bv, n_bv, r_hb, n_hb;
    logic [CW-1:0] r_bc, n_bc, r_boc, n_boc;
    logic [AW-1:0] r_ba, n_ba, r_boa, n_boa;
    logic          r_out_v, n_out_v;
    ashr_pkg::t_out_item r_out, n_out;

    logic          cnt_we;
    logic [AW-1:0] cnt_wa, cnt_ra;
    logic [15:0]   cnt_wd;
    logic          scr_we;
    t_scr          scr_wd;
    logic          pop, out_free;
    logic [CW-1:0] w_sum;
    logic [SW-1:0] e_last;
    logic [JW-1:0] l_last;
    logic [AW-1:0] w_base;
    logic [6:0]    w_kmax;
    logic          w_qual, w_better;

    assign out_free = !r_out_v || !i_out_stall;
    assign w_sum    = r_acc + CW'(r_cnt_q);
    assign w_kmax   = (r_func != ashr_pkg::FN_PRANK) ? 7'(ashr_pkg::GROUP_SIZE) :
                      (r_n >= NW'(ashr_pkg::GROUP_SIZE)) ? 7'(ashr_pkg::GROUP_SIZE) :
                      7'(r_n);
    assign w_qual   = !r_hb || (r_scr_q.c < r_boc) ||
                      ((r_scr_q.c == r_boc) && (r_scr_q.a > r_boa));
    assign w_better = !r_bv || (r_scr_q.c > r_bc) ||
                      ((r_scr_q.c == r_bc) && (r_scr_q.a < r_ba));

    // Walk shape per function: element count and inner length.
    always_comb begin
        e_last = '0;
        l_last = '0;
        w_base = r_addr;
        unique case (r_func)
            ashr_pkg::FN_LSUM: begin
                l_last = JW'(ashr_pkg::GROUP_SIZE - 1);
            end
            ashr_pkg::FN_LDET: begin
                e_last = SW'(ashr_pkg::GROUP_SIZE - 1);
                w_base = r_addr + AW'(r_o);
            end
            ashr_pkg::FN_PDET: begin
                e_last = SW'(ashr_pkg::GROUP_SIZE - 1);
                l_last = JW'(ashr_pkg::GROUP_SIZE - 1);
                w_base = r_addr + (AW'(r_o) << ashr_pkg::GRP_SH);
            end
            ashr_pkg::FN_PRANK: begin
                e_last = SW'(NP - 1);
                l_last = JW'(ashr_pkg::PAGE_BYTES - 1);
                w_base = AW'(r_o) << ashr_pkg::PAGE_SH;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_st = r_st;   n_clr = r_clr;   n_func = r_func;   n_addr = r_addr;
        n_o = r_o;     n_j = r_j;       n_pv = 1'b0;       n_plast = r_plast;
        n_pbase = r_pbase;  n_acc = r_acc;  n_tot = r_tot;  n_nz = r_nz;
        n_k = r_k;     n_n = r_n;       n_si = r_si;       n_spv = 1'b0;
        n_bv = r_bv;   n_bc = r_bc;     n_ba = r_ba;       n_hb = r_hb;
        n_boc = r_boc; n_boa = r_boa;   n_out = r_out;
        n_out_v = r_out_v && i_out_stall;
        cnt_we = 1'b0; cnt_wa = r_addr; cnt_wd = '0; cnt_ra = r_addr;
        scr_we = 1'b0; scr_wd = '{a: r_pbase, c: w_sum};
        pop = 1'b0;

        // Accumulate counter reads of the walk; close an element on its last read.
        if (r_pv) begin
            n_acc = (r_plast && (r_func != ashr_pkg::FN_LSUM)) ? '0 : w_sum;
            if (r_plast && (r_func != ashr_pkg::FN_LSUM)) begin
                n_tot = r_tot + w_sum;
                if (w_sum != '0) begin
                    n_nz = r_nz + 7'd1;
                end
                if ((r_func != ashr_pkg::FN_PRANK) || (w_sum != '0)) begin
                    scr_we = 1'b1;
                    n_n    = r_n + NW'(1);
                end
            end else if ((r_func == ashr_pkg::FN_LSUM) && (r_cnt_q != '0)) begin
                n_nz = r_nz + 7'd1;
            end
        end

        // Track the best entry that ranks after the one emitted last.
        if (r_spv && w_qual && w_better) begin
            n_bv = 1'b1;
            n_bc = r_scr_q.c;
            n_ba = r_scr_q.a;
        end

        unique case (r_st)
            ST_CLR: begin
                cnt_we = 1'b1;
                cnt_wa = r_clr;
                n_clr  = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_st = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    pop    = 1'b1;
                    n_func = i_q_item.func;
                    n_addr = AW'(i_q_item.addr);
                    n_o = '0; n_j = '0; n_acc = '0; n_tot = '0; n_nz = '0;
                    n_n = '0; n_k = '0; n_hb = 1'b0;
                    n_st = (i_q_item.func == ashr_pkg::FN_SAMPLE) ? ST_SRD : ST_WALK;
                end
            end
            ST_SRD: begin
                n_st = ST_SWR;
            end
            ST_SWR: begin
                cnt_we = 1'b1;
                cnt_wd = r_cnt_q + 16'd1;
                n_st   = ST_IDLE;
            end
            ST_WALK: begin
                cnt_ra  = w_base + AW'(r_j);
                n_pv    = 1'b1;
                n_plast = (r_j == l_last);
                n_pbase = w_base;
                if (r_j == l_last) begin
                    n_j = '0;
                    if (r_o == e_last) begin
                        n_st = ST_DRAIN;
                    end else begin
                        n_o = r_o + SW'(1);
                    end
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            ST_DRAIN: begin
                if (!r_pv) begin
                    if (r_func == ashr_pkg::FN_LSUM) begin
                        if (out_free) begin
                            n_out_v = 1'b1;
                            n_out = '{entry_addr: 16'(r_addr), entry_count: r_acc,
                                      group_total: r_acc, nonzero_entries: r_nz,
                                      last: 1'b1};
                            n_st = ST_IDLE;
                        end
                    end else if (r_n == '0) begin
                        n_st = ST_IDLE;
                    end else begin
                        n_si = '0;
                        n_bv = 1'b0;
                        n_st = ST_SEL;
                    end
                end
            end
            ST_SEL: begin
                n_spv = 1'b1;
                if ((NW'(r_si) + NW'(1)) == r_n) begin
                    n_st = ST_SDRAIN;
                end else begin
                    n_si = r_si + SW'(1);
                end
            end
            ST_SDRAIN: begin
                if (!r_spv) begin
                    n_st = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_v = 1'b1;
                    n_out = '{entry_addr: 16'(r_ba), entry_count: r_bc,
                              group_total: (r_func == ashr_pkg::FN_PRANK) ? '0 : r_tot,
                              nonzero_entries: (r_func == ashr_pkg::FN_PRANK) ? w_kmax : r_nz,
                              last: (r_k + 7'd1) == w_kmax};
                    n_hb  = 1'b1;
                    n_boc = r_bc;
                    n_boa = r_ba;
                    n_k   = r_k + 7'd1;
                    n_si  = '0;
                    n_bv  = 1'b0;
                    n_st  = ((r_k + 7'd1) == w_kmax) ? ST_IDLE : ST_SEL;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
            r_spv   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_clr   <= n_clr;
            r_pv    <= n_pv;
            r_spv   <= n_spv;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;  r_addr <= n_addr;  r_o <= n_o;  r_j <= n_j;
        r_plast <= n_plast;  r_pbase <= n_pbase;  r_acc <= n_acc;  r_tot <= n_tot;
        r_nz <= n_nz;  r_k <= n_k;  r_n <= n_n;  r_si <= n_si;
        r_bv <= n_bv;  r_bc <= n_bc;  r_ba <= n_ba;  r_hb <= n_hb;
        r_boc <= n_boc;  r_boa <= n_boa;  r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_q <= r_cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scr_mem[r_n[SW-1:0]] <= scr_wd;
        end
        r_scr_q <= r_scr_mem[r_si];
    end

    assign o_stat.pop      = pop;
    assign o_stat.clearing = (r_st == ST_CLR);
    assign o_out_valid     = r_out_v;
    assign o_out_item      = r_out;
endmodule
